// ===== hdl/shs_pkg.sv =====
// Shared types, constants and functions for the SHA-256 stream hasher.
// Holds the round constant table, the initial hash values and the sigma functions.
// No dependencies; the memories, the round datapath and the top level refer to it by scoped names.
package shs_pkg;

   localparam int unsigned ROUNDS      = 64;
   localparam int unsigned CHAIN_DEPTH = 8;
   localparam int unsigned BLK_DEPTH   = 16;
   localparam logic [7:0]  PAD_BYTE    = 8'h80;
   localparam logic [5:0]  LEN_FILL    = 6'd56;

   // Control of the compression datapath, driven by the sequencer
   typedef struct packed {
      logic       shift;    // shift working words down by one
      logic       rotate;   // shifted-in word is word a (else the chain word)
      logic       gen;      // produce the next schedule word
      logic       use_blk;  // schedule word comes from the block buffer
      logic [5:0] k_idx;    // round constant index for the generated word
      logic       step;     // run one compression round
   } rnd_ctrl_type;

   // Access to the chaining word memory
   typedef struct packed {
      logic        rd_en;
      logic [2:0]  rd_addr;
      logic        wr_en;
      logic [2:0]  wr_addr;
      logic [31:0] wr_data;
      logic        clear;
   } chn_req_type;

   function automatic logic [31:0] init_h(input logic [2:0] idx);
      logic [31:0] v;
      case (idx)
         3'd0: v = 32'h6a09e667;
         3'd1: v = 32'hbb67ae85;
         3'd2: v = 32'h3c6ef372;
         3'd3: v = 32'ha54ff53a;
         3'd4: v = 32'h510e527f;
         3'd5: v = 32'h9b05688c;
         3'd6: v = 32'h1f83d9ab;
         3'd7: v = 32'h5be0cd19;
         default: v = 32'h6a09e667;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] t);
      logic [31:0] v;
      case (t)
         6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
         6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
         6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
         6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
         6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
         6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
         6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
         6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
         6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
         6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
         6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
         6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
         6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
         6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
         6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
         6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
         6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
         6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
         6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
         6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
         6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
         6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
         6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
         6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
         6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
         6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
         6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
         6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
         6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
         6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
         6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
         6'd62: v = 32'hbef9a3f7;  6'd63: v = 32'hc67178f2;
         default: v = 32'h428a2f98;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned n);
      return (v >> n) | (v << (32 - n));
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] v);
      return ror32(v, 2) ^ ror32(v, 13) ^ ror32(v, 22);
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] v);
      return ror32(v, 6) ^ ror32(v, 11) ^ ror32(v, 25);
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] v);
      return ror32(v, 7) ^ ror32(v, 18) ^ (v >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] v);
      return ror32(v, 17) ^ ror32(v, 19) ^ (v >> 10);
   endfunction

endpackage

// ===== hdl/shs_req_if.sv =====
// Input channel of the SHA-256 stream hasher: one optional message byte per item.
// Valid/ready handshake; depends on nothing.
interface shs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       end_of_message;

   modport source (output valid, output data_byte, output byte_valid,
                   output end_of_message, input ready);
   modport sink   (input valid, input data_byte, input byte_valid,
                   input end_of_message, output ready);
endinterface

// ===== hdl/shs_rsp_if.sv =====
// Result channel of the SHA-256 stream hasher: one digest word per item.
// Valid/ready handshake; depends on nothing.
interface shs_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, output digest_word, output word_index,
                   output last_word, input ready);
   modport sink   (input valid, input digest_word, input word_index,
                   input last_word, output ready);
endinterface

// ===== hdl/shs_blk_mem.sv =====
// Block buffer of the hasher: sixteen 32-bit words, one write and one read port.
// Read data is registered. Depends on shs_pkg.
module shs_blk_mem (
   input  logic        clock,
   input  logic        wr_en,
   input  logic [3:0]  wr_addr,
   input  logic [31:0] wr_data,
   input  logic [3:0]  rd_addr,
   output logic [31:0] rd_data
);

   logic [31:0] mem_ff [shs_pkg::BLK_DEPTH];
   logic [31:0] rd_data_ff;

   // write a packed word, read every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/shs_chain_mem.sv =====
// Chaining word memory: eight 32-bit words with one valid bit per entry.
// An entry that is not valid reads as its SHA-256 initial hash value. Depends on shs_pkg.
module shs_chain_mem (
   input  logic                clock,
   input  logic                reset,
   input  shs_pkg::chn_req_type req,
   output logic [31:0]         rd_data
);

   logic [31:0] mem_ff [shs_pkg::CHAIN_DEPTH];
   logic [7:0]  vld_ff;
   logic [7:0]  vld_in;
   logic [31:0] q_ff;
   logic        q_vld_ff;
   logic [2:0]  q_addr_ff;

   // track written entries; clear returns all to the initial values
   always_comb begin
      vld_in = vld_ff;
      if (req.clear) begin
         vld_in = '0;
      end else if (req.wr_en) begin
         vld_in[req.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // storage and registered read
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem_ff[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         q_ff      <= mem_ff[req.rd_addr];
         q_vld_ff  <= vld_ff[req.rd_addr];
         q_addr_ff <= req.rd_addr;
      end
   end

   assign rd_data = q_vld_ff ? q_ff : shs_pkg::init_h(q_addr_ff);

   // the sequencer never reads and writes one entry in the same cycle
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      req.rd_en && req.wr_en |-> req.rd_addr != req.wr_addr)
      else $error("chain memory read and write of the same entry");

   // clearing never coincides with an update
   a_no_clear_wr: assert property (@(posedge clock) disable iff (reset)
      req.clear |-> !req.wr_en)
      else $error("chain memory cleared while written");

endmodule

// ===== hdl/shs_round.sv =====
// Compression datapath: working words a..h, the rolling 16-word schedule and one round.
// Schedule word plus round constant is registered the cycle before its round. Depends on shs_pkg.
module shs_round (
   input  logic                 clock,
   input  shs_pkg::rnd_ctrl_type ctrl,
   input  logic [31:0]          chain_word,
   input  logic [31:0]          blk_word,
   output logic [31:0]          work_a
);

   logic [31:0] work_ff  [8];
   logic [31:0] sched_ff [16];
   logic [31:0] kw_ff;
   logic [31:0] w_new;
   logic [31:0] t1;
   logic [31:0] t2;

   // next schedule word: from the block for the first sixteen rounds
   always_comb begin
      if (ctrl.use_blk) begin
         w_new = blk_word;
      end else begin
         w_new = shs_pkg::small_sigma1(sched_ff[14]) + sched_ff[9]
               + shs_pkg::small_sigma0(sched_ff[1]) + sched_ff[0];
      end
   end

   // round arithmetic on the registered schedule word plus constant
   always_comb begin
      t1 = work_ff[7] + shs_pkg::big_sigma1(work_ff[4])
         + ((work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6])) + kw_ff;
      t2 = shs_pkg::big_sigma0(work_ff[0])
         + ((work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
            ^ (work_ff[1] & work_ff[2]));
   end

   // advance schedule
   always_ff @(posedge clock) begin
      if (ctrl.gen) begin
         for (int i = 0; i < 15; i++) begin
            sched_ff[i] <= sched_ff[i+1];
         end
         sched_ff[15] <= w_new;
         kw_ff        <= shs_pkg::round_k(ctrl.k_idx) + w_new;
      end
   end

   // load, rotate or step the working words
   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         for (int i = 0; i < 7; i++) begin
            work_ff[i] <= work_ff[i+1];
         end
         work_ff[7] <= ctrl.rotate ? work_ff[0] : chain_word;
      end else if (ctrl.step) begin
         work_ff[7] <= work_ff[6];
         work_ff[6] <= work_ff[5];
         work_ff[5] <= work_ff[4];
         work_ff[4] <= work_ff[3] + t1;
         work_ff[3] <= work_ff[2];
         work_ff[2] <= work_ff[1];
         work_ff[1] <= work_ff[0];
         work_ff[0] <= t1 + t2;
      end
   end

   assign work_a = work_ff[0];

endmodule

// ===== hdl/sha256_stream_hasher_top.sv =====
// SHA-256 stream hasher, top level with the byte intake, padding and round sequencer.
// Uses shs_pkg, shs_req_if, shs_rsp_if, shs_blk_mem, shs_chain_mem and shs_round.
//
// Usage:
//  - req_if carries one item per handshake: an optional message byte (byte_valid)
//    and an end-of-message flag. Ready is high only while the sequencer is idle.
//  - Every 64th byte starts a compression: loading the chain words into a..h,
//    the 64 rounds at one per cycle, then updating the chain memory through its
//    single read and write port. No byte is taken until the compression is done.
//  - End of message appends the padding and length one byte per cycle outside
//    compressions (up to 72 bytes, with one or two compressions), then rsp_if
//    gives the eight digest words, word_index 0 first, last_word on word 7.
//  - A stalled rsp_if holds the current word; the sequencer waits. The next
//    message may start while the final word still waits to be taken.
//  - Synchronous reset returns to the initial hash values with an empty block;
//    no clearing pass is needed, the chain memory has a valid bit per entry.
module sha256_stream_hasher_top (
   input  logic      clock,
   input  logic      reset,
   shs_req_if.sink   req_if,
   shs_rsp_if.source rsp_if
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_PAD    = 3'd1;
   localparam logic [2:0] ST_LOAD   = 3'd2;
   localparam logic [2:0] ST_ROUND  = 3'd3;
   localparam logic [2:0] ST_UPD    = 3'd4;
   localparam logic [2:0] ST_OUT_RD = 3'd5;
   localparam logic [2:0] ST_OUT_LD = 3'd6;

   localparam logic [6:0] CNT_CHAIN = 7'(shs_pkg::CHAIN_DEPTH);
   localparam logic [6:0] CNT_ROUND = 7'(shs_pkg::ROUNDS);
   localparam logic [6:0] CNT_BLK   = 7'(shs_pkg::BLK_DEPTH);

   logic [2:0]  state_ff, state_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [5:0]  fill_ff, fill_in;
   logic [23:0] acc_ff, acc_in;
   logic [63:0] msg_bits_ff, msg_bits_in;
   logic        pad_act_ff, pad_act_in;
   logic        pad_first_ff, pad_first_in;
   logic        pad_len_ff, pad_len_in;
   logic [2:0]  len_idx_ff, len_idx_in;
   logic        fin_ff, fin_in;
   logic [2:0]  out_idx_ff, out_idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_word_ff;
   logic [2:0]  rsp_idx_ff;
   logic        rsp_last_ff;

   logic        req_take;
   logic        put_en;
   logic [7:0]  put_byte;
   logic [7:0]  pad_byte;
   logic        pad_len_now;
   logic        blk_full;
   logic        rsp_load;
   logic        blk_wr_en;
   logic [3:0]  blk_rd_addr;
   logic [31:0] blk_rd_data;
   logic [31:0] chain_rd_data;
   logic [31:0] work_a;

   shs_pkg::chn_req_type  chn_req;
   shs_pkg::rnd_ctrl_type rnd_ctrl;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_take     = req_if.valid && req_if.ready;

   // pick the byte for the block: input byte when idle, padding otherwise
   assign pad_len_now = pad_len_ff || (fill_ff == shs_pkg::LEN_FILL);
   always_comb begin
      if (pad_first_ff) begin
         pad_byte = shs_pkg::PAD_BYTE;
      end else if (pad_len_now) begin
         pad_byte = msg_bits_ff[63:56];
      end else begin
         pad_byte = 8'h00;
      end
   end

   assign put_en    = (req_take && req_if.byte_valid) || (state_ff == ST_PAD);
   assign put_byte  = (state_ff == ST_PAD) ? pad_byte : req_if.data_byte;
   assign blk_full  = put_en && (fill_ff == 6'd63);
   assign blk_wr_en = put_en && (fill_ff[1:0] == 2'b11);
   assign rsp_load  = (state_ff == ST_OUT_LD) && (!rsp_valid_ff || rsp_if.ready);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      fill_in      = put_en ? fill_ff + 6'd1 : fill_ff;
      acc_in       = put_en ? {acc_ff[15:0], put_byte} : acc_ff;
      msg_bits_in  = msg_bits_ff;
      pad_act_in   = pad_act_ff;
      pad_first_in = pad_first_ff;
      pad_len_in   = pad_len_ff;
      len_idx_in   = len_idx_ff;
      fin_in       = fin_ff;
      out_idx_in   = out_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end

      chn_req          = '0;
      rnd_ctrl         = '0;
      rnd_ctrl.k_idx   = cnt_ff[5:0];
      blk_rd_addr      = 4'd0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_if.byte_valid) begin
                  msg_bits_in = msg_bits_ff + 64'd8;
               end
               if (req_if.end_of_message) begin
                  pad_act_in   = 1'b1;
                  pad_first_in = 1'b1;
               end
               if (blk_full) begin
                  state_in = ST_LOAD;
                  cnt_in   = '0;
               end else if (req_if.end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            // 0x80 first, zeros up to byte 56, then the length big-endian
            if (pad_first_ff) begin
               pad_first_in = 1'b0;
            end else if (pad_len_now) begin
               msg_bits_in = {msg_bits_ff[55:0], 8'h00};
               if (!pad_len_ff) begin
                  pad_len_in = 1'b1;
                  len_idx_in = 3'd1;
               end else if (len_idx_ff == 3'd7) begin
                  pad_len_in = 1'b0;
                  len_idx_in = 3'd0;
                  pad_act_in = 1'b0;
                  fin_in     = 1'b1;
               end else begin
                  len_idx_in = len_idx_ff + 3'd1;
               end
            end
            if (blk_full) begin
               state_in = ST_LOAD;
               cnt_in   = '0;
            end
         end
         ST_LOAD: begin
            // read chain words 0..7 and shift them into a..h
            chn_req.rd_en   = (cnt_ff < CNT_CHAIN);
            chn_req.rd_addr = cnt_ff[2:0];
            rnd_ctrl.shift  = (cnt_ff != '0);
            cnt_in          = cnt_ff + 7'd1;
            if (cnt_ff == CNT_CHAIN) begin
               state_in = ST_ROUND;
               cnt_in   = '0;
            end
         end
         ST_ROUND: begin
            // schedule word for round cnt, round cnt-1 on the previous one
            rnd_ctrl.gen     = (cnt_ff < CNT_ROUND);
            rnd_ctrl.use_blk = (cnt_ff < CNT_BLK);
            rnd_ctrl.step    = (cnt_ff != '0);
            blk_rd_addr      = cnt_ff[3:0] + 4'd1;
            cnt_in           = cnt_ff + 7'd1;
            if (cnt_ff == CNT_ROUND) begin
               state_in = ST_UPD;
               cnt_in   = '0;
            end
         end
         ST_UPD: begin
            // read entry n while entry n-1 takes its sum with word a
            chn_req.rd_en   = (cnt_ff < CNT_CHAIN);
            chn_req.rd_addr = cnt_ff[2:0];
            chn_req.wr_en   = (cnt_ff != '0);
            chn_req.wr_addr = cnt_ff[2:0] - 3'd1;
            chn_req.wr_data = chain_rd_data + work_a;
            rnd_ctrl.shift  = (cnt_ff != '0);
            rnd_ctrl.rotate = 1'b1;
            cnt_in          = cnt_ff + 7'd1;
            if (cnt_ff == CNT_CHAIN) begin
               cnt_in = '0;
               if (fin_ff) begin
                  state_in = ST_OUT_RD;
               end else if (pad_act_ff) begin
                  state_in = ST_PAD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_OUT_RD: begin
            chn_req.rd_en   = 1'b1;
            chn_req.rd_addr = out_idx_ff;
            state_in        = ST_OUT_LD;
         end
         ST_OUT_LD: begin
            if (rsp_load) begin
               if (out_idx_ff == 3'd7) begin
                  // digest out: back to the initial hash values
                  chn_req.clear = 1'b1;
                  fin_in        = 1'b0;
                  out_idx_in    = 3'd0;
                  state_in      = ST_IDLE;
               end else begin
                  out_idx_in = out_idx_ff + 3'd1;
                  state_in   = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         fill_ff      <= '0;
         msg_bits_ff  <= '0;
         pad_act_ff   <= 1'b0;
         pad_first_ff <= 1'b0;
         pad_len_ff   <= 1'b0;
         len_idx_ff   <= '0;
         fin_ff       <= 1'b0;
         out_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         fill_ff      <= fill_in;
         msg_bits_ff  <= msg_bits_in;
         pad_act_ff   <= pad_act_in;
         pad_first_ff <= pad_first_in;
         pad_len_ff   <= pad_len_in;
         len_idx_ff   <= len_idx_in;
         fin_ff       <= fin_in;
         out_idx_ff   <= out_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (rsp_load) begin
         rsp_word_ff <= chain_rd_data;
         rsp_idx_ff  <= out_idx_ff;
         rsp_last_ff <= (out_idx_ff == 3'd7);
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.digest_word = rsp_word_ff;
   assign rsp_if.word_index  = rsp_idx_ff;
   assign rsp_if.last_word   = rsp_last_ff;

   shs_blk_mem u_blk_mem (
      .clock   (clock),
      .wr_en   (blk_wr_en),
      .wr_addr (fill_ff[5:2]),
      .wr_data ({acc_ff, put_byte}),
      .rd_addr (blk_rd_addr),
      .rd_data (blk_rd_data)
   );

   shs_chain_mem u_chain_mem (
      .clock   (clock),
      .reset   (reset),
      .req     (chn_req),
      .rd_data (chain_rd_data)
   );

   shs_round u_round (
      .clock      (clock),
      .ctrl       (rnd_ctrl),
      .chain_word (chain_rd_data),
      .blk_word   (blk_rd_data),
      .work_a     (work_a)
   );

   // a compression always starts on an empty block
   a_load_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD |-> fill_ff == '0)
      else $error("compression started with a partly filled block");

   // the length bytes fill the last eight places of the block
   a_len_tail: assert property (@(posedge clock) disable iff (reset)
      pad_len_ff |-> fill_ff[5:3] == 3'b111)
      else $error("length bytes outside the block tail");

   // digest words leave in order
   a_word_order: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.ready && !rsp_if.last_word
      |=> !rsp_if.valid || rsp_if.word_index == 3'($past(rsp_if.word_index) + 3'd1))
      else $error("digest words out of order");

   // no digest readout and no intake during the rounds
   a_no_out_in_rounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROUND |-> out_idx_ff == '0 && !req_if.ready)
      else $error("readout or intake during compression");

endmodule

// ===== bench/tb_sha256_stream_hasher_top.sv =====
// Self-checking bench for the SHA-256 stream hasher: directed rows, then random messages.
// Every digest word is checked against a SHA-256 model in this file or a typed-in known digest.
// Needs hdl/shs_pkg.sv, hdl/shs_req_if.sv, hdl/shs_rsp_if.sv and the hasher RTL.
module tb_sha256_stream_hasher_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned LIMIT_CYCLES = 2000000;
   localparam int unsigned RANDOM_ITEMS = 360;
   localparam int unsigned SETTLE_CYCLES = 250;
   localparam logic [7:0]  PAD_MARK = 8'h80;
   localparam int unsigned LEN_SLOT = 56;

   localparam logic [255:0] EMPTY_DIGEST =
      256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
   localparam logic [255:0] ABC_DIGEST =
      256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

   localparam logic [31:0] START_WORDS [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [31:0] ROUND_CONST [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   typedef struct packed {
      logic [7:0]   data;
      logic         has_byte;
      logic         ends;
      logic         known;
      logic [255:0] digest;
   } stim_row_type;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   // Directed rows; a digest is typed in only for the well-known vectors
   localparam int unsigned N_DIRECTED = 11;
   localparam stim_row_type DIRECTED_ROWS [N_DIRECTED] = '{
      '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},   // empty message straight after reset
      '{8'h00, 1'b0, 1'b1, 1'b0, 256'd0},         // empty message after a restart
      '{8'hff, 1'b1, 1'b1, 1'b0, 256'd0},         // byte and end together, all ones
      '{8'h00, 1'b1, 1'b1, 1'b0, 256'd0},         // single zero byte
      '{8'haa, 1'b0, 1'b0, 1'b0, 256'd0},         // invalid byte, ignored
      '{8'h61, 1'b1, 1'b0, 1'b0, 256'd0},
      '{8'h55, 1'b0, 1'b0, 1'b0, 256'd0},         // invalid byte inside a message
      '{8'h62, 1'b1, 1'b0, 1'b0, 256'd0},
      '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},     // "abc", end on the last byte
      '{8'h00, 1'b0, 1'b0, 1'b0, 256'd0},
      '{8'hff, 1'b0, 1'b1, 1'b0, 256'd0}};        // end with an ignored all-ones byte

   logic clock;
   logic reset;

   shs_req_if req_ch ();
   shs_rsp_if rsp_ch ();

   sha256_stream_hasher_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch.sink),
      .rsp_if (rsp_ch.source)
   );

   // Model state
   logic [31:0] chain_h [8];
   logic [7:0]  block_bytes [64];
   int unsigned block_fill;
   logic [63:0] length_bits;

   digest_word_type pending_words [$];
   int unsigned     err_count;
   int unsigned     cycle_count;
   int unsigned     ready_stall_pct;

   function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
      return (v >> n) | (v << (32 - n));
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r < 14) return $urandom_range(1, 3);
      if (r < 19) return $urandom_range(4, 8);
      return $urandom_range(10, 40);
   endfunction

   task automatic restart_hash();
      for (int i = 0; i < 8; i++) chain_h[i] = START_WORDS[i];
      block_fill  = 0;
      length_bits = '0;
   endtask

   // One 64-round compression of the held block into the chaining words
   task automatic compress_block();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      for (int t = 0; t < 16; t++)
         w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
      for (int t = 16; t < 64; t++) begin
         s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
         s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
         w[t] = w[t-16] + s0 + w[t-7] + s1;
      end
      a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
      e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
      for (int t = 0; t < 64; t++) begin
         t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
              + ROUND_CONST[t] + w[t];
         t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
      chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
   endtask

   task automatic append_byte(input logic [7:0] b);
      block_bytes[block_fill] = b;
      block_fill++;
      if (block_fill == 64) begin
         compress_block();
         block_fill = 0;
      end
   endtask

   // Absorb one accepted item; on end of message give the digest and restart
   task automatic absorb_item(input logic [7:0] data, input logic has_byte, input logic ends,
                              output logic [255:0] digest, output bit done);
      logic [63:0] len;
      done   = 1'b0;
      digest = '0;
      if (has_byte) begin
         length_bits += 64'd8;
         append_byte(data);
      end
      if (ends) begin
         len = length_bits;
         append_byte(PAD_MARK);
         while (block_fill != LEN_SLOT) append_byte(8'h00);
         for (int i = 0; i < 8; i++) append_byte(len[63 - 8*i -: 8]);
         digest = {chain_h[0], chain_h[1], chain_h[2], chain_h[3],
                   chain_h[4], chain_h[5], chain_h[6], chain_h[7]};
         done = 1'b1;
         restart_hash();
      end
   endtask

   // Drive one item and wait for it to be taken, then book its digest words
   task automatic send_item(input logic [7:0] data, input logic has_byte, input logic ends,
                            input logic known, input logic [255:0] known_digest);
      logic [255:0]    digest;
      bit              done;
      digest_word_type dw;
      @(negedge clock);
      req_ch.valid          <= 1'b1;
      req_ch.data_byte      <= data;
      req_ch.byte_valid     <= has_byte;
      req_ch.end_of_message <= ends;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      absorb_item(data, has_byte, ends, digest, done);
      if (done) begin
         if (known) digest = known_digest;
         for (int i = 0; i < 8; i++) begin
            dw.word  = digest[255 - 32*i -: 32];
            dw.index = i[2:0];
            dw.last  = (i == 7);
            pending_words.push_back(dw);
         end
      end
   endtask

   // Drop valid and hold the channel idle; the argument n sets the length of the gap
   task automatic idle_for(input int unsigned n);
      if (n > 0) begin
         @(negedge clock);
         req_ch.valid          <= 1'b0;
         req_ch.data_byte      <= 8'($urandom);
         req_ch.byte_valid     <= 1'($urandom);
         req_ch.end_of_message <= 1'($urandom);
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // Hold off until every booked digest word has been taken
   task automatic wait_drained();
      idle_for(1);
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Cycle limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("%0t timeout after %0d cycles, %0d words outstanding", $time, cycle_count,
                  pending_words.size());
         $display("status: fail");
         $finish;
      end
   end

   // Result side back-pressure; the stall rate is picked anew for each phase of random length
   initial begin
      int unsigned stall_left;
      int unsigned phase_left;
      rsp_ch.ready    = 1'b0;
      stall_left      = 0;
      phase_left      = 0;
      ready_stall_pct = 0;
      forever begin
         @(negedge clock);
         if (phase_left == 0) begin
            case ($urandom_range(0, 2))
               0: ready_stall_pct = 0;
               1: ready_stall_pct = 10;
               default: ready_stall_pct = 35;
            endcase
            phase_left = $urandom_range(100, 400);
         end
         phase_left--;
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 99) < ready_stall_pct) stall_left = pick_gap();
         end
      end
   end

   // Check each taken digest word against the oldest booked one
   always @(posedge clock) begin
      digest_word_type exp_w;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_words.size() == 0) begin
            err_count++;
            $display("%0t unexpected word: expected none, actual %h index %0d last %0b",
                     $time, rsp_ch.digest_word, rsp_ch.word_index, rsp_ch.last_word);
         end else begin
            exp_w = pending_words.pop_front();
            if (rsp_ch.digest_word !== exp_w.word) begin
               err_count++;
               $display("%0t digest_word mismatch: expected %h actual %h", $time,
                        exp_w.word, rsp_ch.digest_word);
            end
            if (rsp_ch.word_index !== exp_w.index) begin
               err_count++;
               $display("%0t word_index mismatch: expected %0d actual %0d", $time,
                        exp_w.index, rsp_ch.word_index);
            end
            if (rsp_ch.last_word !== exp_w.last) begin
               err_count++;
               $display("%0t last_word mismatch: expected %0b actual %0b", $time,
                        exp_w.last, rsp_ch.last_word);
            end
         end
      end
   end

   // Main sequence
   initial begin
      int unsigned payload_items;
      int unsigned msg_len;
      int unsigned msg_count;
      int unsigned idle_pct;
      int unsigned pick;
      bit          end_with_byte;
      err_count             = 0;
      reset                 = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.data_byte      = 8'h00;
      req_ch.byte_valid     = 1'b0;
      req_ch.end_of_message = 1'b0;
      restart_hash();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed rows
      for (int r = 0; r < N_DIRECTED; r++) begin
         send_item(DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].has_byte, DIRECTED_ROWS[r].ends,
                   DIRECTED_ROWS[r].known, DIRECTED_ROWS[r].digest);
         if ($urandom_range(0, 3) == 0) idle_for(pick_gap());
      end
      wait_drained();

      // Random messages: mostly short, some on the padding boundaries, a few long
      payload_items = 0;
      msg_count     = 0;
      while (payload_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick < 5) msg_len = $urandom_range(0, 12);
         else if (pick < 8) begin
            case ($urandom_range(0, 7))
               0: msg_len = 55;
               1: msg_len = 56;
               2: msg_len = 57;
               3: msg_len = 63;
               4: msg_len = 64;
               5: msg_len = 65;
               6: msg_len = 119;
               default: msg_len = 120;
            endcase
         end else if (pick < 9) msg_len = $urandom_range(13, 130);
         else msg_len = 0;

         case ($urandom_range(0, 2))
            0: idle_pct = 0;
            1: idle_pct = 10;
            default: idle_pct = 35;
         endcase
         end_with_byte = (msg_len != 0) && $urandom_range(0, 1);

         for (int unsigned n = 0; n < msg_len; n++) begin
            // Sprinkle ignored items through the message
            if ($urandom_range(0, 9) == 0) begin
               send_item(8'($urandom), 1'b0, 1'b0, 1'b0, 256'd0);
               payload_items++;
            end
            send_item(8'($urandom), 1'b1, end_with_byte && (n == msg_len - 1), 1'b0, 256'd0);
            payload_items++;
            if ($urandom_range(0, 99) < idle_pct) idle_for(pick_gap());
         end
         if (!end_with_byte) begin
            send_item(8'($urandom), 1'b0, 1'b1, 1'b0, 256'd0);
            payload_items++;
         end
         msg_count++;

         // Now and then, and once for certain, let the digest drain first
         if (msg_count == 3 || $urandom_range(0, 6) == 0) wait_drained();
         else if ($urandom_range(0, 99) < idle_pct) idle_for(pick_gap());
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_words.size() != 0) begin
         err_count++;
         $display("%0t %0d digest words never arrived", $time, pending_words.size());
      end
      if (err_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/shs_pkg.sv
hdl/shs_req_if.sv
hdl/shs_rsp_if.sv
hdl/shs_blk_mem.sv
hdl/shs_chain_mem.sv
hdl/shs_round.sv
hdl/sha256_stream_hasher_top.sv
bench/tb_sha256_stream_hasher_top.sv
